// ----- src/mvrl_pkg.sv -----
// shared types, constants and symbol tables of the run/level decoder
package mvrl_pkg;

  // register indexes
  localparam logic [1:0] REG_QUANT = 2'd0;
  localparam logic [1:0] REG_RAW_DC = 2'd1;
  localparam logic [1:0] REG_FRAME_LEN = 2'd2;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] EOB_WORD = 16'hFE00;

  // symbol kinds from the ac decoder
  localparam logic [1:0] AC_SYM = 2'd0;
  localparam logic [1:0] AC_EOB = 2'd1;
  localparam logic [1:0] AC_TERM = 2'd2;

  typedef struct packed {
    logic [15:0] stream_word;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [15:0] code_word;
    logic        last_of_run;
    logic        stream_end;
    logic [18:0] fill_count;
  } out_t;

  typedef struct packed {
    logic [5:0]  quant_scale;
    logic        raw_dc;
    logic [15:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code;
    logic [4:0]  len;
  } ac_res_t;

  // run in the high byte, level in the low byte
  function automatic logic [15:0] pk(input int r, input int l);
    logic [31:0] rr;
    logic [31:0] ll;
    rr = 32'(r);
    ll = 32'(l);
    return {rr[7:0], ll[7:0]};
  endfunction

  localparam logic [15:0] AC_G5 [3] = '{pk(0, 3), pk(4, 1), pk(3, 1)};
  localparam logic [15:0] AC_G6 [4] = '{pk(7, 1), pk(6, 1), pk(1, 2), pk(5, 1)};
  localparam logic [15:0] AC_G7 [4] = '{pk(2, 2), pk(9, 1), pk(0, 4), pk(8, 1)};
  localparam logic [15:0] AC_G8 [8] = '{pk(13, 1), pk(0, 6), pk(12, 1), pk(11, 1),
                                        pk(3, 2), pk(1, 3), pk(0, 5), pk(10, 1)};
  localparam logic [15:0] AC_G10 [8] = '{pk(16, 1), pk(5, 2), pk(0, 7), pk(2, 3),
                                         pk(1, 4), pk(15, 1), pk(14, 1), pk(4, 2)};
  localparam logic [15:0] AC_LONG [80] = '{
    pk(0, 11), pk(8, 2), pk(4, 3), pk(0, 10), pk(2, 4), pk(7, 2), pk(21, 1), pk(20, 1),
    pk(0, 9), pk(19, 1), pk(18, 1), pk(1, 5), pk(3, 3), pk(0, 8), pk(6, 2), pk(17, 1),
    pk(10, 2), pk(9, 2), pk(5, 3), pk(3, 4), pk(2, 5), pk(1, 7), pk(1, 6), pk(0, 15),
    pk(0, 14), pk(0, 13), pk(0, 12), pk(26, 1), pk(25, 1), pk(24, 1), pk(23, 1), pk(22, 1),
    pk(0, 31), pk(0, 30), pk(0, 29), pk(0, 28), pk(0, 27), pk(0, 26), pk(0, 25), pk(0, 24),
    pk(0, 23), pk(0, 22), pk(0, 21), pk(0, 20), pk(0, 19), pk(0, 18), pk(0, 17), pk(0, 16),
    pk(0, 40), pk(0, 39), pk(0, 38), pk(0, 37), pk(0, 36), pk(0, 35), pk(0, 34), pk(0, 33),
    pk(0, 32), pk(1, 14), pk(1, 13), pk(1, 12), pk(1, 11), pk(1, 10), pk(1, 9), pk(1, 8),
    pk(1, 18), pk(1, 17), pk(1, 16), pk(1, 15), pk(6, 3), pk(16, 2), pk(15, 2), pk(14, 2),
    pk(13, 2), pk(12, 2), pk(11, 2), pk(31, 1), pk(30, 1), pk(29, 1), pk(28, 1), pk(27, 1)
  };

  // decode one ac symbol from the top of a 32-bit window
  function automatic ac_res_t ac_decode(input logic [31:0] win);
    ac_res_t     res;
    logic [16:0] c;
    logic [4:0]  t;
    logic [6:0]  u;
    logic [2:0]  g5i;
    logic [15:0] pv;
    logic [4:0]  sidx;
    logic [9:0]  lev;
    logic [6:0]  li;
    res.kind = AC_SYM;
    res.code = 16'd0;
    res.len = 5'd0;
    c = win[31:15];
    t = c[16:12];
    u = c[14:8];
    g5i = u[6:4] - 3'd5;
    pv = 16'd0;
    li = 7'd0;
    if (c[16:15] != 2'd0) begin
      if (t[4:3] == 2'b10) begin
        res.kind = AC_EOB;
        res.len = 5'd2;
      end else if (t[4:3] == 2'b11) begin
        pv = pk(0, 1);
        res.len = 5'd3;
      end else if (t >= 5'd12) begin
        pv = pk(1, 1);
        res.len = 5'd4;
      end else if (t >= 5'd10) begin
        pv = pk(2, 1);
        res.len = 5'd5;
      end else begin
        pv = pk(0, 2);
        res.len = 5'd5;
      end
    end else if (c[14:11] != 4'd0) begin
      if (u < 7'd16) begin
        res.len = 5'd22;
      end else if (u < 7'd32) begin
        pv = AC_G7[u[3:2]];
        res.len = 5'd8;
      end else if (u < 7'd64) begin
        pv = AC_G6[u[4:3]];
        res.len = 5'd7;
      end else if (u < 7'd80) begin
        pv = AC_G8[u[3:1]];
        res.len = 5'd9;
      end else begin
        pv = AC_G5[g5i[1:0]];
        res.len = 5'd6;
      end
    end else if (c[10]) begin
      pv = AC_G10[c[9:7]];
      res.len = 5'd11;
    end else if (c[9]) begin
      li = {3'd0, c[8:5]};
      res.len = 5'd13;
    end else if (c[8]) begin
      li = 7'd16 + {3'd0, c[7:4]};
      res.len = 5'd14;
    end else if (c[7]) begin
      li = 7'd32 + {3'd0, c[6:3]};
      res.len = 5'd15;
    end else if (c[6]) begin
      li = 7'd48 + {3'd0, c[5:2]};
      res.len = 5'd16;
    end else if (c[5]) begin
      li = 7'd64 + {3'd0, c[4:1]};
      res.len = 5'd17;
    end else begin
      res.kind = AC_TERM;
    end
    if (c[16:10] == 7'd0 && c[9:5] != 5'd0) begin
      pv = AC_LONG[li];
    end
    // sign bit follows the code
    sidx = 5'(6'd32 - {1'b0, res.len});
    lev = {2'b00, pv[7:0]};
    if (win[sidx]) begin
      lev = 10'(10'd0 - lev);
    end
    if (res.kind == AC_EOB) begin
      res.code = EOB_WORD;
    end else if (c[16:15] == 2'd0 && c[14:11] != 4'd0 && u < 7'd16) begin
      res.code = win[25:10];
    end else begin
      res.code = {pv[13:8], lev};
    end
    return res;
  endfunction

endpackage

// ----- src/mvrl_front.sv -----
// input side: takes stream beats into a short queue ahead of the decoder
module mvrl_front #(
  parameter int unsigned Depth = mvrl_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mvrl_pkg::in_t  in_data_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output mvrl_pkg::in_t  q_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  mvrl_pkg::in_t  mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q;
  logic [AW-1:0]  rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           push;
  logic           pop;

  assign in_ready_o = (cnt_q != CW'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/mvrl_back.sv -----
// decode side: bit buffer, symbol decoder, predictors and result staging
module mvrl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mvrl_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  mvrl_pkg::in_t  q_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mvrl_pkg::out_t out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]     state_q;
  logic [47:0]    buf_q;
  logic [5:0]     bc_q;
  logic [9:0]     pred_q [3];
  logic [2:0]     bi_q;
  logic           exp_dc_q;
  logic [18:0]    oc_q;
  logic           fin_q;
  mvrl_pkg::out_t pend_q;
  logic           pend_v_q;
  mvrl_pkg::out_t out_q;
  logic           out_v_q;

  logic [18:0]       limit;
  logic [31:0]       win;
  logic              out_free;
  logic              out_load;
  mvrl_pkg::ac_res_t ac;

  // dc decode signals
  logic [5:0]  t;
  logic        luma;
  logic [1:0]  comp;
  logic        dc_zero;
  logic [4:0]  dc_b;
  logic [5:0]  dc_len;
  logic [4:0]  bb;
  logic        stop;
  logic [16:0] dmask;
  logic [16:0] dv;
  logic [16:0] dsub;
  logic [7:0]  val8;
  logic [9:0]  delta;
  logic [9:0]  pred_new;
  logic [15:0] dc_code;

  assign limit = 19'(({3'd0, cfg_i.frame_length} + 19'd2) << 2);
  assign win = 32'(buf_q >> bc_q[3:0]);
  assign out_free = !out_v_q || out_ready_i;
  assign ac = mvrl_pkg::ac_decode(win);
  assign q_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  // pending beat moves to the output register this cycle
  always_comb begin
    out_load = 1'b0;
    if (pend_v_q && out_free) begin
      if (state_q == ST_FLUSH) begin
        out_load = 1'b1;
      end else if (state_q == ST_RUN) begin
        if (exp_dc_q && oc_q >= limit) begin
          out_load = 1'b1;
        end else if (bc_q >= 6'd32 &&
                     ((!exp_dc_q && ac.kind == mvrl_pkg::AC_TERM) || oc_q < limit)) begin
          out_load = 1'b1;
        end
      end
    end
  end

  // dc size, escape prefix and predictor update
  always_comb begin
    t = win[31:26];
    luma = (bi_q >= 3'd2);
    comp = luma ? 2'd2 : bi_q[1:0];
    dc_zero = 1'b0;
    dc_b = 5'd1;
    dc_len = 6'd2;
    bb = 5'd0;
    stop = 1'b0;
    if (luma) begin
      if (t[5:4] == 2'b00) begin
        dc_b = 5'd1;
        dc_len = 6'd3;
      end else if (t[5:4] == 2'b01) begin
        dc_b = 5'd2;
        dc_len = 6'd4;
      end else if (t[5:3] == 3'b100) begin
        dc_zero = 1'b1;
        dc_len = 6'd3;
      end else if (t[5:3] == 3'b101) begin
        dc_b = 5'd3;
        dc_len = 6'd6;
      end else begin
        bb = 5'd15;
        for (int p = 3; p < 15; p++) begin
          if (!stop && !win[32-p]) begin
            bb = 5'(p);
            stop = 1'b1;
          end
        end
        dc_b = bb + 5'd1;
        dc_len = 6'({dc_b, 1'b0} - 6'd1);
      end
    end else begin
      if (t[5:4] == 2'b00) begin
        dc_zero = 1'b1;
        dc_len = 6'd2;
      end else if (t[5:4] == 2'b01) begin
        dc_b = 5'd1;
        dc_len = 6'd3;
      end else if (t[5:4] == 2'b10) begin
        dc_b = 5'd2;
        dc_len = 6'd4;
      end else if (t[5:3] == 3'b110) begin
        dc_b = 5'd3;
        dc_len = 6'd6;
      end else begin
        bb = 5'd16;
        for (int p = 4; p < 16; p++) begin
          if (!stop && !win[32-p]) begin
            bb = 5'(p);
            stop = 1'b1;
          end
        end
        dc_b = bb;
        dc_len = {dc_b, 1'b0};
      end
    end
    dmask = 17'((17'd1 << dc_b) - 17'd1);
    dv = 17'(win >> (6'd32 - dc_len)) & dmask;
    dsub = dv - dmask;
    val8 = ((dv & (17'd1 << (dc_b - 5'd1))) != 17'd0) ? dv[7:0] : dsub[7:0];
    delta = dc_zero ? 10'd0 : {val8, 2'b00};
    pred_new = pred_q[comp] + delta;
    if (cfg_i.raw_dc) begin
      dc_code = {cfg_i.quant_scale, win[31:22]};
    end else begin
      dc_code = {cfg_i.quant_scale, pred_new};
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      buf_q <= '0;
      bc_q <= '0;
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      pred_q[2] <= '0;
      bi_q <= '0;
      exp_dc_q <= 1'b1;
      oc_q <= 19'd2;
      fin_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_load || (out_v_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            if (q_data_i.frame_start) begin
              pred_q[0] <= '0;
              pred_q[1] <= '0;
              pred_q[2] <= '0;
              bi_q <= '0;
              exp_dc_q <= 1'b1;
              oc_q <= 19'd2;
              fin_q <= 1'b0;
              buf_q <= {32'd0, q_data_i.stream_word};
              bc_q <= 6'd16;
              state_q <= ST_RUN;
            end else if (!fin_q) begin
              buf_q <= {buf_q[31:0], q_data_i.stream_word};
              bc_q <= bc_q + 6'd16;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (exp_dc_q && oc_q >= limit) begin
            // output limit reached at a block start
            if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                out_q <= pend_q;
              end
              pend_q <= '{code_word: 16'd0, last_of_run: 1'b0, stream_end: 1'b1,
                          fill_count: 19'd0};
              pend_v_q <= 1'b1;
              fin_q <= 1'b1;
              state_q <= ST_FLUSH;
            end
          end else if (bc_q < 6'd32) begin
            state_q <= ST_FLUSH;
          end else if (!exp_dc_q && ac.kind == mvrl_pkg::AC_TERM) begin
            // twelve leading zeros end the frame
            if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                out_q <= pend_q;
              end
              pend_q <= '{code_word: 16'd0, last_of_run: 1'b0, stream_end: 1'b1,
                          fill_count: (limit > oc_q) ? limit - oc_q : 19'd0};
              pend_v_q <= 1'b1;
              fin_q <= 1'b1;
              state_q <= ST_FLUSH;
            end
          end else if (oc_q >= limit || !pend_v_q || out_free) begin
            // ordinary symbol
            if (oc_q < limit) begin
              if (pend_v_q) begin
                out_q <= pend_q;
              end
              pend_q <= '{code_word: exp_dc_q ? dc_code : ac.code, last_of_run: 1'b0,
                          stream_end: 1'b0, fill_count: 19'd0};
              pend_v_q <= 1'b1;
              oc_q <= oc_q + 19'd1;
            end
            if (exp_dc_q) begin
              if (cfg_i.raw_dc) begin
                bc_q <= bc_q - 6'd10;
              end else begin
                bc_q <= bc_q - dc_len;
                pred_q[comp] <= pred_new;
                bi_q <= (bi_q >= 3'd5) ? 3'd0 : bi_q + 3'd1;
              end
              exp_dc_q <= 1'b0;
            end else begin
              bc_q <= bc_q - {1'b0, ac.len};
              if (ac.kind == mvrl_pkg::AC_EOB) begin
                exp_dc_q <= 1'b1;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_q <= '{code_word: pend_q.code_word, last_of_run: 1'b1,
                       stream_end: pend_q.stream_end, fill_count: pend_q.fill_count};
            pend_v_q <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/mdec_vlc_run_level_decoder.sv -----
// top level of the compressed macroblock run/level decoder
// Each 16-bit stream beat leaves the input queue while the back end is idle;
// the back end then decodes symbols from the bit buffer (a word yields zero
// to nine results) until it finds the buffer short of a full window or the
// frame ends, then releases its final result, and only then takes the next
// word. The single symbol decoder in the back end decodes one symbol per
// cycle while the output side does not stall. The input queue holds
// QueueDepth beats so the source keeps going while the decoder works.
module mdec_vlc_run_level_decoder #(
  parameter int unsigned QueueDepth = mvrl_pkg::QueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mvrl_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mvrl_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [mvrl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mvrl_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  mvrl_pkg::cfg_t cfg_q;
  logic           q_valid;
  logic           q_ready;
  mvrl_pkg::in_t  q_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mvrl_pkg::REG_QUANT: begin
          cfg_q.quant_scale <= cfg_wdata_i[5:0];
        end
        mvrl_pkg::REG_RAW_DC: begin
          cfg_q.raw_dc <= cfg_wdata_i[0];
        end
        mvrl_pkg::REG_FRAME_LEN: begin
          cfg_q.frame_length <= cfg_wdata_i[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input queue
  mvrl_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  // symbol decoder
  mvrl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // an end-of-frame beat is always the last of its word and carries no code
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stream_end |->
      out_data_o.last_of_run && out_data_o.code_word == 16'd0)
    else $error("end-of-frame beat not last or has code");
  // fill count only on end-of-frame beats
  a_fill_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fill_count != 19'd0 |-> out_data_o.stream_end)
    else $error("fill count on ordinary beat");
`endif

endmodule

// ----- test/mdec_vlc_run_level_decoder_checker.sv -----
// checker for the run/level decoder: tracks accepted beats, predicts codes, compares
`timescale 1ns / 1ps
module mdec_vlc_run_level_decoder_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  mvrl_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  mvrl_pkg::out_t out_data_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_o
);

  typedef enum logic [1:0] {SYM_AC, SYM_EOB, SYM_TERM} sym_kind_e;

  localparam logic [15:0] SH_G5 [3] = '{16'h0003, 16'h0401, 16'h0301};
  localparam logic [15:0] SH_G6 [4] = '{16'h0701, 16'h0601, 16'h0102, 16'h0501};
  localparam logic [15:0] SH_G7 [4] = '{16'h0202, 16'h0901, 16'h0004, 16'h0801};
  localparam logic [15:0] SH_G8 [8] = '{16'h0D01, 16'h0006, 16'h0C01, 16'h0B01,
                                        16'h0302, 16'h0103, 16'h0005, 16'h0A01};
  localparam logic [15:0] SH_G10 [8] = '{16'h1001, 16'h0502, 16'h0007, 16'h0203,
                                         16'h0104, 16'h0F01, 16'h0E01, 16'h0402};
  localparam logic [15:0] LONG_TAB [80] = '{
    16'h000B, 16'h0802, 16'h0403, 16'h000A, 16'h0204, 16'h0702, 16'h1501, 16'h1401,
    16'h0009, 16'h1301, 16'h1201, 16'h0105, 16'h0303, 16'h0008, 16'h0602, 16'h1101,
    16'h0A02, 16'h0902, 16'h0503, 16'h0304, 16'h0205, 16'h0107, 16'h0106, 16'h000F,
    16'h000E, 16'h000D, 16'h000C, 16'h1A01, 16'h1901, 16'h1801, 16'h1701, 16'h1601,
    16'h001F, 16'h001E, 16'h001D, 16'h001C, 16'h001B, 16'h001A, 16'h0019, 16'h0018,
    16'h0017, 16'h0016, 16'h0015, 16'h0014, 16'h0013, 16'h0012, 16'h0011, 16'h0010,
    16'h0028, 16'h0027, 16'h0026, 16'h0025, 16'h0024, 16'h0023, 16'h0022, 16'h0021,
    16'h0020, 16'h010E, 16'h010D, 16'h010C, 16'h010B, 16'h010A, 16'h0109, 16'h0108,
    16'h0112, 16'h0111, 16'h0110, 16'h010F, 16'h0603, 16'h1002, 16'h0F02, 16'h0E02,
    16'h0D02, 16'h0C02, 16'h0B02, 16'h1F01, 16'h1E01, 16'h1D01, 16'h1C01, 16'h1B01
  };

  // decoder state copy
  logic [5:0]  quant;
  logic        raw_mode;
  logic [15:0] frame_len;
  logic [47:0] bitbuf;
  int unsigned nbits;
  logic [9:0]  dc_pred [3];
  int unsigned blk;
  bit          want_dc;
  int unsigned emitted;
  bit          done;
  mvrl_pkg::out_t expected_codes [$];

  assign pending_o = expected_codes.size();

  function automatic int signed signed_size(int unsigned v, int unsigned s);
    if (v & (1 << (s - 1))) return int'(v);
    return int'(v) - int'((1 << s) - 1);
  endfunction

  function automatic logic [15:0] signed_ac(logic [31:0] win, logic [15:0] pkv, int unsigned n);
    logic [9:0] lev;
    lev = {2'b0, pkv[7:0]};
    if (win[32 - n]) lev = 10'd0 - lev;
    return {pkv[13:8], lev};
  endfunction

  // one ac symbol from the top of the window
  function automatic sym_kind_e ac_symbol(logic [31:0] win, output logic [15:0] code,
                                          output int unsigned n);
    int unsigned c, t, u, k;
    logic [15:0] pkv;
    c = win >> 15;
    code = 16'd0;
    n = 0;
    if (c >= (1 << 15)) begin
      t = c >> 12;
      if (t >= 16 && t < 24) begin
        code = mvrl_pkg::EOB_WORD; n = 2; return SYM_EOB;
      end
      if (t >= 24) begin pkv = 16'h0001; n = 3; end
      else if (t >= 12) begin pkv = 16'h0101; n = 4; end
      else if (t >= 10) begin pkv = 16'h0201; n = 5; end
      else begin pkv = 16'h0002; n = 5; end
    end else if (c >= (1 << 11)) begin
      u = c >> 8;
      if (u < 16) begin
        code = win[25:10]; n = 22; return SYM_AC;
      end
      if (u < 32) begin pkv = SH_G7[(u >> 2) & 3]; n = 8; end
      else if (u < 64) begin pkv = SH_G6[(u >> 3) & 3]; n = 7; end
      else if (u < 80) begin pkv = SH_G8[(u >> 1) & 7]; n = 9; end
      else begin pkv = SH_G5[((u >> 4) & 7) - 5]; n = 6; end
    end else if (c >= (1 << 10)) begin
      pkv = SH_G10[(c >> 7) & 7]; n = 11;
    end else begin
      for (k = 0; k < 5; k++) if (c >= (1 << (9 - k))) break;
      if (k == 5) return SYM_TERM;
      pkv = LONG_TAB[k * 16 + ((c >> (5 - k)) & 15)];
      n = 13 + k;
    end
    code = signed_ac(win, pkv, n);
    return SYM_AC;
  endfunction

  // dc symbol, updates predictor and block index unless in raw mode
  function automatic logic [15:0] dc_symbol(logic [31:0] win, output int unsigned n);
    int unsigned t, comp, v, b;
    int signed val;
    t = win >> 26;
    if (raw_mode) begin
      n = 10; return {quant, win[31:22]};
    end
    if (blk >= 2) begin
      comp = 2;
      if (t < 16) begin n = 3; val = signed_size((t >> 3) & 1, 1); end
      else if (t < 32) begin n = 4; val = signed_size((t >> 2) & 3, 2); end
      else if (t < 40) begin n = 3; val = 0; end
      else if (t < 48) begin n = 6; val = signed_size(t & 7, 3); end
      else begin
        b = 3;
        while (b < 15 && win[32 - b]) b++;
        b++;
        n = 2 * b - 1;
        v = (win >> (32 - n)) & ((1 << b) - 1);
        val = signed_size(v, b);
      end
    end else begin
      comp = blk;
      if (t < 16) begin n = 2; val = 0; end
      else if (t < 32) begin n = 3; val = signed_size((t >> 3) & 1, 1); end
      else if (t < 48) begin n = 4; val = signed_size((t >> 2) & 3, 2); end
      else if (t < 56) begin n = 6; val = signed_size(t & 7, 3); end
      else begin
        b = 4;
        while (b < 16 && win[32 - b]) b++;
        n = 2 * b;
        v = (win >> (32 - n)) & ((1 << b) - 1);
        val = signed_size(v, b);
      end
    end
    dc_pred[comp] = 10'(dc_pred[comp] + 10'(val << 2));
    blk = (blk >= 5) ? 0 : blk + 1;
    return {quant, dc_pred[comp]};
  endfunction

  function automatic void clear_frame();
    bitbuf = '0; nbits = 0;
    dc_pred[0] = '0; dc_pred[1] = '0; dc_pred[2] = '0;
    blk = 0; want_dc = 1; emitted = 2; done = 0;
  endfunction

  function automatic void push_code(logic [15:0] code, bit fin, int unsigned fill);
    mvrl_pkg::out_t r;
    r.code_word = code; r.last_of_run = 0; r.stream_end = fin; r.fill_count = 19'(fill);
    expected_codes.push_back(r);
  endfunction

  // expected codes for one stream word
  function automatic void decode_word(mvrl_pkg::in_t beat);
    int unsigned lim, n, first;
    logic [31:0] win;
    logic [15:0] code;
    sym_kind_e kind;
    first = expected_codes.size();
    if (beat.frame_start) clear_frame();
    if (done) return;
    bitbuf = {bitbuf[31:0], beat.stream_word};
    nbits += 16;
    forever begin
      lim = (frame_len + 2) * 4;
      if (want_dc && emitted >= lim) begin
        push_code(16'd0, 1, 0); done = 1; break;
      end
      if (nbits < 32 || nbits > 48) break;
      win = 32'(bitbuf >> (nbits - 32));
      if (want_dc) begin
        code = dc_symbol(win, n);
        want_dc = 0;
      end else begin
        kind = ac_symbol(win, code, n);
        if (kind == SYM_TERM) begin
          push_code(16'd0, 1, lim > emitted ? lim - emitted : 0);
          done = 1; break;
        end
        if (kind == SYM_EOB) want_dc = 1;
      end
      if (emitted < lim) begin
        push_code(code, 0, 0); emitted++;
      end
      nbits -= n;
    end
    if (expected_codes.size() > first)
      expected_codes[expected_codes.size() - 1].last_of_run = 1;
  endfunction

  // config, input and output beats
  always @(posedge clk_i or negedge rst_ni) begin
    mvrl_pkg::out_t e;
    if (!rst_ni) begin
      quant = '0; raw_mode = 0; frame_len = '0;
      clear_frame();
      expected_codes.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mvrl_pkg::REG_QUANT:     quant = cfg_wdata_i[5:0];
          mvrl_pkg::REG_RAW_DC:    raw_mode = cfg_wdata_i[0];
          mvrl_pkg::REG_FRAME_LEN: frame_len = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected beat: code_word %h", out_data_i.code_word);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_codes.pop_front();
          if (e != out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (e.code_word != out_data_i.code_word)
              $error("code_word exp %h got %h", e.code_word, out_data_i.code_word);
            if (e.last_of_run != out_data_i.last_of_run)
              $error("last_of_run exp %0d got %0d", e.last_of_run, out_data_i.last_of_run);
            if (e.stream_end != out_data_i.stream_end)
              $error("stream_end exp %0d got %0d", e.stream_end, out_data_i.stream_end);
            if (e.fill_count != out_data_i.fill_count)
              $error("fill_count exp %0d got %0d", e.fill_count, out_data_i.fill_count);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_word(in_data_i);
    end
  end
endmodule

// ----- test/mdec_vlc_run_level_decoder_test.sv -----
// top of the run/level decoder testbench: stimulus, config phases and verdict
`timescale 1ns / 1ps
module mdec_vlc_run_level_decoder_test;

  localparam int unsigned IdleLimit = 4000;

  logic           clk, rst_n;
  logic           in_valid, in_ready, out_valid, out_ready;
  mvrl_pkg::in_t  in_data;
  mvrl_pkg::out_t out_data;
  logic           cfg_we;
  logic [1:0]     cfg_idx;
  logic [15:0]    cfg_wdata;
  int             fail_count, pending;
  bit             hold_sink;
  int unsigned    idle_cycles;

  mdec_vlc_run_level_decoder u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  mdec_vlc_run_level_decoder_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus a long hold on request
  initial begin
    int unsigned g;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  // watchdog on accepted beats
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL mdec_vlc_run_level_decoder");
        $finish;
      end
    end
  end

  task automatic send_word(logic [15:0] w, logic fs);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{stream_word: w, frame_start: fs};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // random word biased to short symbols so frames run deep
  function automatic logic [15:0] stream_rand();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(16'h4000, 16'hFFFF));
    if (r < 8) return 16'($urandom);
    return 16'($urandom_range(0, 16'h00FF));
  endfunction

  initial begin
    int unsigned ph, k;
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_we = 0; cfg_idx = mvrl_pkg::REG_QUANT; cfg_wdata = '0; hold_sink = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, eob, escape, terminator, limit
    write_reg(mvrl_pkg::REG_QUANT, 16'd63);
    write_reg(mvrl_pkg::REG_RAW_DC, 16'd1);
    write_reg(mvrl_pkg::REG_FRAME_LEN, 16'd65535);
    send_word(16'hFFFF, 1);
    send_word(16'hFFFF, 0);
    send_word(16'h8000, 0);
    send_word(16'h0000, 0);
    send_word(16'h0400, 0);
    send_word(16'h0000, 0);
    send_word(16'h0000, 0);
    send_word(16'h1234, 0);
    drain_all();
    write_reg(mvrl_pkg::REG_RAW_DC, 16'd0);
    write_reg(mvrl_pkg::REG_QUANT, 16'd0);
    write_reg(mvrl_pkg::REG_FRAME_LEN, 16'd0);
    send_word(16'hFFFF, 1);
    send_word(16'hFFFF, 0);
    send_word(16'hFFFF, 0);
    send_word(16'h0000, 0);
    send_word(16'h0000, 0);
    drain_all();
    write_reg(mvrl_pkg::REG_FRAME_LEN, 16'd1000);
    send_word(16'h0000, 1);
    send_word(16'h0000, 0);
    send_word(16'hFFFF, 0);
    send_word(16'h0000, 0);
    send_word(16'h5555, 0);
    send_word(16'hAAAA, 0);
    send_word(16'h0000, 0);
    send_word(16'h0000, 0);
    drain_all();

    // random phases with varied settings
    for (ph = 0; ph < 6; ph++) begin
      write_reg(mvrl_pkg::REG_QUANT, 16'($urandom_range(0, 63)));
      write_reg(mvrl_pkg::REG_RAW_DC, 16'($urandom_range(0, 1)));
      write_reg(mvrl_pkg::REG_FRAME_LEN,
                (ph == 5) ? 16'd65535 : 16'($urandom_range(0, 40)));
      if (ph == 2) hold_sink = 1;
      for (k = 0; k < 56; k++)
        send_word(stream_rand(), (k == 0) || ($urandom_range(0, 19) == 0));
      drain_all();
    end

    if (fail_count == 0) begin
      $display("PASS mdec_vlc_run_level_decoder");
    end else begin
      $display("FAIL mdec_vlc_run_level_decoder");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/mvrl_pkg.sv
src/mvrl_front.sv
src/mvrl_back.sv
src/mdec_vlc_run_level_decoder.sv
test/mdec_vlc_run_level_decoder_checker.sv
test/mdec_vlc_run_level_decoder_test.sv
